[src/rist_pkg.sv]
package rist_pkg;

    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_PUT   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_LOAD      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_HELD      = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;
    localparam logic [2:0] ST_SATURATED = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] lookup_inode;
        logic [5:0]  slot;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic [15:0] inode_out;
        logic [7:0]  count_out;
        logic        need_read;
        logic        need_write;
    } resp_t;

    typedef struct packed {
        logic live;
        logic match;
        logic at_max;
        logic to_zero;
    } unit_flags_t;

    function automatic resp_t make_resp(
        input logic [2:0]  status,
        input logic [5:0]  slot_out,
        input logic [15:0] inode_out,
        input logic [7:0]  count_out,
        input logic        need_read,
        input logic        need_write
    );
        resp_t r;
        r.status     = status;
        r.slot_out   = slot_out;
        r.inode_out  = inode_out;
        r.count_out  = count_out;
        r.need_read  = need_read;
        r.need_write = need_write;
        return r;
    endfunction

endpackage

[src/refcounted_inode_slot_table_core.sv]
// get: scans all slots for a match or a free slot; next request after the result
// put: reads the slot, then updates it; clear: sweeps all slots
// one table slot is read per cycle through the single memory read port
// reset: synchronous active-low aresetn, then a sweep pass zeroes every count
// s_ready stays low during that pass
module refcounted_inode_slot_table_core #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rist_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rist_pkg::resp_t m_data
);
    import rist_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0]      LAST    = IDX_W'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef enum logic [2:0] {IDLE, SWEEP, SCAN, PUT_RD, PUT_UPD, FINISH} state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  issue_done_reg;
    logic                  chk_vld_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  chk_last_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [15:0]           key_reg;
    logic [5:0]            slot_in_reg;
    logic                  sweep_emit_reg;
    resp_t                 res_reg;
    logic                  m_valid_reg;
    resp_t                 m_data_reg;

    logic [15:0]           rd_inode;
    logic [COUNT_BITS-1:0] rd_count;
    unit_flags_t           flags;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                  claim_ok;
    logic [IDX_W-1:0]      claim_idx;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [15:0]           mem_winode;
    logic [COUNT_BITS-1:0] mem_wcount;

    rist_table #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .aclk   (aclk),
        .raddr  (idx_reg),
        .rinode (rd_inode),
        .rcount (rd_count),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .winode (mem_winode),
        .wcount (mem_wcount)
    );

    rist_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_unit (
        .cnt     (rd_count),
        .inode   (rd_inode),
        .key     (key_reg),
        .flags   (flags),
        .cnt_inc (cnt_inc),
        .cnt_dec (cnt_dec)
    );

    assign claim_ok  = free_found_reg || !flags.live;
    assign claim_idx = free_found_reg ? free_idx_reg : chk_idx_reg;

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_winode = key_reg;
        mem_wcount = '0;
        unique case (state_reg)
            SWEEP: begin
                mem_we = 1'b1;
            end
            SCAN: begin
                if (chk_vld_reg) begin
                    if (flags.match) begin
                        mem_we     = 1'b1;
                        mem_waddr  = chk_idx_reg;
                        mem_wcount = cnt_inc;
                    end else if (chk_last_reg && claim_ok) begin
                        mem_we     = 1'b1;
                        mem_waddr  = claim_idx;
                        mem_wcount = CNT_ONE;
                    end
                end
            end
            PUT_UPD: begin
                if (flags.live) begin
                    mem_we     = 1'b1;
                    mem_winode = rd_inode;
                    mem_wcount = cnt_dec;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SWEEP;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            chk_last_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            sweep_emit_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        key_reg     <= s_data.lookup_inode;
                        slot_in_reg <= s_data.slot;
                        unique case (s_data.req_type)
                            REQ_GET: begin
                                idx_reg        <= '0;
                                issue_done_reg <= 1'b0;
                                chk_vld_reg    <= 1'b0;
                                chk_last_reg   <= 1'b0;
                                free_found_reg <= 1'b0;
                                state_reg      <= SCAN;
                            end
                            REQ_PUT: begin
                                if (32'(s_data.slot) < SLOTS) begin
                                    idx_reg   <= IDX_W'(s_data.slot);
                                    state_reg <= PUT_RD;
                                end else begin
                                    res_reg   <= make_resp(ST_IGNORED, s_data.slot, 16'd0,
                                                           8'd0, 1'b0, 1'b0);
                                    state_reg <= FINISH;
                                end
                            end
                            REQ_CLEAR: begin
                                idx_reg        <= '0;
                                sweep_emit_reg <= 1'b1;
                                state_reg      <= SWEEP;
                            end
                            default: begin
                                res_reg   <= make_resp(ST_IGNORED, 6'd0, 16'd0, 8'd0,
                                                       1'b0, 1'b0);
                                state_reg <= FINISH;
                            end
                        endcase
                    end
                end
                SWEEP: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST) begin
                        sweep_emit_reg <= 1'b0;
                        if (sweep_emit_reg) begin
                            res_reg   <= make_resp(ST_CLEARED, 6'd0, 16'd0, 8'd0,
                                                   1'b0, 1'b0);
                            state_reg <= FINISH;
                        end else begin
                            state_reg <= IDLE;
                        end
                    end
                end
                SCAN: begin
                    if (!issue_done_reg) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == LAST) begin
                            issue_done_reg <= 1'b1;
                        end
                    end
                    chk_vld_reg  <= !issue_done_reg;
                    chk_idx_reg  <= idx_reg;
                    chk_last_reg <= (idx_reg == LAST);
                    if (chk_vld_reg) begin
                        if (flags.match) begin
                            res_reg   <= make_resp(flags.at_max ? ST_SATURATED : ST_HIT,
                                                   6'(chk_idx_reg), key_reg, 8'(cnt_inc),
                                                   1'b0, 1'b0);
                            state_reg <= FINISH;
                        end else if (chk_last_reg) begin
                            if (claim_ok) begin
                                res_reg <= make_resp(ST_LOAD, 6'(claim_idx), key_reg, 8'd1,
                                                     1'b1, 1'b0);
                            end else begin
                                res_reg <= make_resp(ST_FULL, 6'd0, key_reg, 8'd0,
                                                     1'b0, 1'b0);
                            end
                            state_reg <= FINISH;
                        end else if (!flags.live && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                        end
                    end
                end
                PUT_RD: begin
                    state_reg <= PUT_UPD;
                end
                PUT_UPD: begin
                    if (!flags.live) begin
                        res_reg <= make_resp(ST_IGNORED, slot_in_reg, 16'd0, 8'd0,
                                             1'b0, 1'b0);
                    end else if (flags.to_zero) begin
                        res_reg <= make_resp(ST_RELEASED, slot_in_reg, rd_inode, 8'd0,
                                             1'b0, 1'b1);
                    end else begin
                        res_reg <= make_resp(ST_HELD, slot_in_reg, rd_inode, 8'(cnt_dec),
                                             1'b0, 1'b0);
                    end
                    state_reg <= FINISH;
                end
                FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("ready high right after reset, before the count clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready still high after a request transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == IDLE) |-> !mem_we)
        else $error("table write while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == FINISH))
        else $error("result raised outside the finish step");
endmodule

[src/rist_table.sv]
module rist_table #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 8,
    parameter int IDX_W      = 6
) (
    input  logic                  aclk,
    input  logic [IDX_W-1:0]      raddr,
    output logic [15:0]           rinode,
    output logic [COUNT_BITS-1:0] rcount,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [15:0]           winode,
    input  logic [COUNT_BITS-1:0] wcount
);
    logic [15:0]           inode_mem [SLOTS];
    logic [COUNT_BITS-1:0] count_mem [SLOTS];
    logic [15:0]           rinode_reg;
    logic [COUNT_BITS-1:0] rcount_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            inode_mem[waddr] <= winode;
            count_mem[waddr] <= wcount;
        end
        rinode_reg <= inode_mem[raddr];
        rcount_reg <= count_mem[raddr];
    end

    assign rinode = rinode_reg;
    assign rcount = rcount_reg;
endmodule

[src/rist_unit.sv]
module rist_unit #(
    parameter int COUNT_BITS = 8
) (
    input  logic [COUNT_BITS-1:0]  cnt,
    input  logic [15:0]            inode,
    input  logic [15:0]            key,
    output rist_pkg::unit_flags_t  flags,
    output logic [COUNT_BITS-1:0]  cnt_inc,
    output logic [COUNT_BITS-1:0]  cnt_dec
);
    import rist_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    always_comb begin
        flags.live    = (cnt != '0);
        flags.match   = (cnt != '0) && (inode == key);
        flags.at_max  = &cnt;
        flags.to_zero = (cnt == CNT_ONE);
        cnt_inc       = (&cnt) ? cnt : cnt + CNT_ONE;
        cnt_dec       = cnt - CNT_ONE;
    end
endmodule
